>>> hdl/imu_complementary_attitude_filter_unit_defines.svh
// Assertion macros for the attitude filter unit.
// Used by the top level; relies on clk and arst_n in the including scope.
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_UNIT_DEFINES_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ICAF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ICAF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ICAF_ASSERT_NOW(label, ante, cons, msg)
`define ICAF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/imu_caf_pkg.sv
// Package for the attitude filter unit: word types, register indexes,
// Q2.30 angle constants and the CORDIC arctangent table. No dependencies.
package imu_caf_pkg;

	typedef logic signed [31:0] sword_t;
	typedef logic [31:0] word_t;

	localparam int CORDIC_ITERATIONS = 24;
	localparam int ITER_W = $clog2(CORDIC_ITERATIONS);

	localparam logic [1:0] CFG_TIME_STEP = 2'd0;
	localparam logic [1:0] CFG_ACCEL_WEIGHT = 2'd1;

	localparam word_t TIME_STEP_RST = 32'd10737418;
	localparam word_t ACCEL_WEIGHT_RST = 32'd1717987;

	localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] r;
		case (idx)
			5'd0: r = 30'd843314857;
			5'd1: r = 30'd497837829;
			5'd2: r = 30'd263043837;
			5'd3: r = 30'd133525159;
			5'd4: r = 30'd67021687;
			5'd5: r = 30'd33543516;
			5'd6: r = 30'd16775851;
			5'd7: r = 30'd8388437;
			5'd8: r = 30'd4194283;
			5'd9: r = 30'd2097149;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			5'd24: r = 30'd64;
			5'd25: r = 30'd32;
			5'd26: r = 30'd16;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			5'd30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/imu_complementary_attitude_filter_unit.sv
// Attitude filter: gyro integration, yaw-rate coupling and accelerometer blend.
// With a zero accelerometer vector the blend is skipped and accel_invalid is set.
// One request at a time; the work runs through the bit-serial multiplier (up to 14
// products per request), the bit-serial square root and the one-step-a-cycle CORDIC.
// Asynchronous active-low reset: angles cleared, registers to defaults, idle.
`include "imu_complementary_attitude_filter_unit_defines.svh"
module imu_complementary_attitude_filter_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  imu_caf_pkg::word_t    cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  imu_caf_pkg::sword_t   rate_x,
	input  imu_caf_pkg::sword_t   rate_y,
	input  imu_caf_pkg::sword_t   rate_z,
	input  imu_caf_pkg::sword_t   accel_x,
	input  imu_caf_pkg::sword_t   accel_y,
	input  imu_caf_pkg::sword_t   accel_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output imu_caf_pkg::sword_t   pitch_angle,
	output imu_caf_pkg::sword_t   roll_angle,
	output imu_caf_pkg::sword_t   yaw_angle,
	output logic                  accel_invalid
);
	import imu_caf_pkg::*;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_MUL       = 5'd1;
	localparam logic [4:0] S_INT_ADD   = 5'd2;
	localparam logic [4:0] S_MOD       = 5'd3;
	localparam logic [4:0] S_ANG       = 5'd4;
	localparam logic [4:0] S_FOLD      = 5'd5;
	localparam logic [4:0] S_COR       = 5'd6;
	localparam logic [4:0] S_CPL_S     = 5'd7;
	localparam logic [4:0] S_CPL_ROLL  = 5'd8;
	localparam logic [4:0] S_CPL_LD    = 5'd9;
	localparam logic [4:0] S_CPL_PITCH = 5'd10;
	localparam logic [4:0] S_ASIN      = 5'd11;
	localparam logic [4:0] S_SQ_B      = 5'd12;
	localparam logic [4:0] S_SQ_C      = 5'd13;
	localparam logic [4:0] S_SQRT      = 5'd14;
	localparam logic [4:0] S_NORM      = 5'd15;
	localparam logic [4:0] S_ASIN_END  = 5'd16;
	localparam logic [4:0] S_BL_LD     = 5'd17;
	localparam logic [4:0] S_BLEND     = 5'd18;
	localparam logic [4:0] S_OUT       = 5'd19;

	localparam logic [1:0] AX_PITCH = 2'd0;
	localparam logic [1:0] AX_ROLL  = 2'd1;
	localparam logic [1:0] AX_YAW   = 2'd2;

	function automatic word_t mag32(input sword_t v);
		word_t r;
		r = v[31] ? (~word_t'(v) + 32'd1) : word_t'(v);
		return r;
	endfunction

	function automatic logic [33:0] mag34(input logic signed [33:0] v);
		logic [33:0] r;
		r = v[33] ? (~v + 34'd1) : v;
		return r;
	endfunction

	function automatic sword_t sat36(input logic signed [35:0] v);
		sword_t r;
		if (v > 36'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -36'sd2147483648)
			r = 32'sh80000000;
		else
			r = signed'(v[31:0]);
		return r;
	endfunction

	function automatic logic signed [35:0] ext36(input sword_t v);
		return {{4{v[31]}}, v};
	endfunction

	logic [4:0]  state_q, ret_q;
	logic [1:0]  k_q;
	word_t       dt_q, w_q;
	sword_t      rx_q, ry_q, rz_q, ax_q, ay_q, az_q;
	sword_t      pitch_q, roll_q, yaw_q;
	logic [63:0] mul_p_q;
	word_t       mcand_q;
	logic [4:0]  mul_cnt_q;
	logic [45:0] r_q;
	logic [3:0]  mod_j_q;
	logic signed [47:0] x_q, y_q;
	logic signed [33:0] z_q, s_q;
	logic [ITER_W-1:0]  cor_i_q;
	logic        vec_q;
	logic [63:0] sum_q, res_q, bit_q;
	sword_t      acc_q;
	logic        neg_q, invalid_q;
	logic        out_valid_q, inv_out_q;
	sword_t      pa_q, ra_q, ya_q;

	logic        in_accept;
	logic        mul_load;
	word_t       mul_a, mul_b;
	logic [4:0]  mul_ret;
	sword_t      cur_rate, nxt_rate, cur_est, ax_a, ax_b, ax_c;

	assign in_stall = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign pitch_angle = pa_q;
	assign roll_angle = ra_q;
	assign yaw_angle = ya_q;
	assign accel_invalid = inv_out_q;

	always_comb begin
		case (k_q)
			AX_PITCH: begin
				cur_rate = ry_q; nxt_rate = rx_q; cur_est = pitch_q;
				ax_a = ax_q; ax_b = ay_q; ax_c = az_q;
			end
			AX_ROLL: begin
				cur_rate = rx_q; nxt_rate = rz_q; cur_est = roll_q;
				ax_a = ay_q; ax_b = ax_q; ax_c = az_q;
			end
			default: begin
				cur_rate = rz_q; nxt_rate = rz_q; cur_est = yaw_q;
				ax_a = az_q; ax_b = ax_q; ax_c = ay_q;
			end
		endcase
	end

	// multiplier step
	logic [32:0] mul_sum;
	assign mul_sum = {1'b0, mul_p_q[63:32]} + (mul_p_q[0] ? {1'b0, mcand_q} : 33'd0);

	// integration rounding
	logic [63:0] int_rnd;
	logic signed [35:0] int_delta;
	logic [63:0] m30_sum;
	assign int_rnd = mul_p_q + 64'h8000_0000;
	assign int_delta = cur_rate[31] ? -$signed({4'b0, int_rnd[63:32]})
	                                : $signed({4'b0, int_rnd[63:32]});
	assign m30_sum = mul_p_q + 64'h2_0000;

	// modulo reduction
	logic [45:0] mod_c;
	assign mod_c = 46'(TWO_PI_Q30) << mod_j_q;

	// angle range and fold
	logic signed [34:0] ang0, ang1, ang2, zf, zfold;
	always_comb begin
		ang0 = $signed({2'b0, r_q[32:0]});
		ang1 = (ang0 > $signed({3'b0, PI_Q30})) ? ang0 - $signed({2'b0, TWO_PI_Q30}) : ang0;
		ang2 = rz_q[31] ? -ang1 : ang1;
		zf = $signed({z_q[33], z_q});
		if (zf > $signed({4'b0, HALF_PI_Q30}))
			zfold = $signed({3'b0, PI_Q30}) - zf;
		else if (zf < -$signed({4'b0, HALF_PI_Q30}))
			zfold = -$signed({3'b0, PI_Q30}) - zf;
		else
			zfold = zf;
	end

	// CORDIC step
	logic signed [47:0] x_sh, y_sh;
	logic signed [33:0] at34;
	logic cor_plus;
	assign x_sh = x_q >>> cor_i_q;
	assign y_sh = y_q >>> cor_i_q;
	assign at34 = $signed({4'b0, atan_q30(5'(cor_i_q))});
	assign cor_plus = vec_q ? y_q[47] : !z_q[33];

	// coupling
	logic signed [33:0] s_src;
	logic [33:0] s_mag;
	logic [63:0] cpl_sum;
	logic cpl_neg;
	logic signed [35:0] cpl_delta;
	assign s_src = (state_q == S_CPL_S) ? y_q[33:0] : s_q;
	assign s_mag = mag34(s_src);
	assign cpl_sum = mul_p_q + 64'h2000_0000;
	assign cpl_neg = ((state_q == S_CPL_ROLL) ? pitch_q[31] : roll_q[31]) ^ s_q[33];
	assign cpl_delta = cpl_neg ? -$signed({2'b0, cpl_sum[63:30]})
	                           : $signed({2'b0, cpl_sum[63:30]});

	// square root step
	logic [63:0] sq_t, res_nx;
	logic sq_ge;
	assign sq_t = res_q + bit_q;
	assign sq_ge = sum_q >= sq_t;
	assign res_nx = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// arcsine finish and blend
	logic signed [33:0] zs, zr;
	logic signed [32:0] bl_d;
	logic [32:0] bl_dmag;
	logic signed [65:0] bl_x, bl_t;
	logic signed [34:0] bl_new;
	assign zs = ax_a[31] ? -z_q : z_q;
	assign zr = zs + 34'sd8192;
	assign bl_d = $signed({acc_q[31], acc_q}) - $signed({cur_est[31], cur_est});
	assign bl_dmag = bl_d[32] ? (~bl_d + 33'd1) : bl_d;
	assign bl_x = neg_q ? -$signed({2'b0, mul_p_q}) : $signed({2'b0, mul_p_q});
	assign bl_t = bl_x + 66'sd2147483648;
	assign bl_new = $signed({{3{cur_est[31]}}, cur_est}) + $signed({bl_t[65], bl_t[65:32]});

	always_comb begin
		mul_load = 1'b0;
		mul_a = '0;
		mul_b = '0;
		mul_ret = S_IDLE;
		case (state_q)
			S_IDLE: if (in_accept) begin
				mul_load = 1'b1; mul_a = mag32(rate_y); mul_b = dt_q; mul_ret = S_INT_ADD;
			end
			S_INT_ADD: if (k_q != AX_YAW) begin
				mul_load = 1'b1; mul_a = mag32(nxt_rate); mul_b = dt_q; mul_ret = S_INT_ADD;
			end
			S_CPL_S, S_CPL_LD: begin
				mul_load = 1'b1;
				mul_a = mag32((state_q == S_CPL_S) ? pitch_q : roll_q);
				mul_b = s_mag[31:0];
				mul_ret = (state_q == S_CPL_S) ? S_CPL_ROLL : S_CPL_PITCH;
			end
			S_ASIN: begin
				mul_load = 1'b1; mul_a = mag32(ax_b); mul_b = mag32(ax_b); mul_ret = S_SQ_B;
			end
			S_SQ_B: begin
				mul_load = 1'b1; mul_a = mag32(ax_c); mul_b = mag32(ax_c); mul_ret = S_SQ_C;
			end
			S_BL_LD: begin
				mul_load = 1'b1; mul_a = bl_dmag[31:0]; mul_b = w_q; mul_ret = S_BLEND;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ret_q <= S_IDLE; k_q <= AX_PITCH;
			dt_q <= TIME_STEP_RST; w_q <= ACCEL_WEIGHT_RST;
			rx_q <= '0; ry_q <= '0; rz_q <= '0; ax_q <= '0; ay_q <= '0; az_q <= '0;
			pitch_q <= '0; roll_q <= '0; yaw_q <= '0;
			mul_p_q <= '0; mcand_q <= '0; mul_cnt_q <= '0;
			r_q <= '0; mod_j_q <= '0;
			x_q <= '0; y_q <= '0; z_q <= '0; s_q <= '0; cor_i_q <= '0; vec_q <= 1'b0;
			sum_q <= '0; res_q <= '0; bit_q <= '0; acc_q <= '0;
			neg_q <= 1'b0; invalid_q <= 1'b0;
			out_valid_q <= 1'b0; inv_out_q <= 1'b0;
			pa_q <= '0; ra_q <= '0; ya_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIME_STEP: dt_q <= cfg_data;
					CFG_ACCEL_WEIGHT: w_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (mul_load) begin
				mul_p_q <= {32'd0, mul_b};
				mcand_q <= mul_a;
				mul_cnt_q <= '0;
				ret_q <= mul_ret;
				state_q <= S_MUL;
			end
			case (state_q)
				S_IDLE: if (in_accept) begin
					rx_q <= rate_x; ry_q <= rate_y; rz_q <= rate_z;
					ax_q <= accel_x; ay_q <= accel_y; az_q <= accel_z;
					k_q <= AX_PITCH;
				end
				S_MUL: begin
					mul_p_q <= {mul_sum, mul_p_q[31:1]};
					mul_cnt_q <= mul_cnt_q + 5'd1;
					if (mul_cnt_q == 5'd31)
						state_q <= ret_q;
				end
				S_INT_ADD: begin
					case (k_q)
						AX_PITCH: pitch_q <= sat36(ext36(pitch_q) + int_delta);
						AX_ROLL: roll_q <= sat36(ext36(roll_q) + int_delta);
						default: yaw_q <= sat36(ext36(yaw_q) + int_delta);
					endcase
					if (k_q == AX_YAW) begin
						r_q <= m30_sum[63:18];
						mod_j_q <= 4'd13;
						state_q <= S_MOD;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_MOD: begin
					if (r_q >= mod_c)
						r_q <= r_q - mod_c;
					if (mod_j_q == 4'd0)
						state_q <= S_ANG;
					else
						mod_j_q <= mod_j_q - 4'd1;
				end
				S_ANG: begin
					z_q <= ang2[33:0];
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					z_q <= zfold[33:0];
					x_q <= $signed({18'd0, INV_GAIN_Q30});
					y_q <= '0;
					vec_q <= 1'b0;
					cor_i_q <= '0;
					state_q <= S_COR;
				end
				S_COR: begin
					if (cor_plus) begin
						x_q <= x_q - y_sh;
						y_q <= y_q + x_sh;
						z_q <= z_q - at34;
					end else begin
						x_q <= x_q + y_sh;
						y_q <= y_q - x_sh;
						z_q <= z_q + at34;
					end
					cor_i_q <= cor_i_q + ITER_W'(1);
					if (cor_i_q == ITER_W'(CORDIC_ITERATIONS - 1))
						state_q <= vec_q ? S_ASIN_END : S_CPL_S;
				end
				S_CPL_S: s_q <= y_q[33:0];
				S_CPL_ROLL: begin
					roll_q <= sat36(ext36(roll_q) - cpl_delta);
					state_q <= S_CPL_LD;
				end
				S_CPL_LD, S_ASIN: ;
				S_CPL_PITCH: begin
					pitch_q <= sat36(ext36(pitch_q) + cpl_delta);
					k_q <= AX_PITCH;
					if (ax_q == '0 && ay_q == '0 && az_q == '0) begin
						invalid_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						invalid_q <= 1'b0;
						state_q <= S_ASIN;
					end
				end
				S_SQ_B: sum_q <= mul_p_q;
				S_SQ_C: begin
					sum_q <= sum_q + mul_p_q;
					res_q <= '0;
					bit_q <= 64'd1 << 62;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sq_ge)
						sum_q <= sum_q - sq_t;
					res_q <= res_nx;
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						x_q <= $signed({16'd0, res_nx[31:0]});
						y_q <= $signed({16'd0, mag32(ax_a)});
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (x_q[47:40] == '0 && y_q[47:40] == '0) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						z_q <= '0;
						cor_i_q <= '0;
						vec_q <= 1'b1;
						state_q <= S_COR;
					end
				end
				S_ASIN_END: begin
					acc_q <= {{12{zr[33]}}, zr[33:14]};
					state_q <= S_BL_LD;
				end
				S_BL_LD: neg_q <= bl_d[32];
				S_BLEND: begin
					case (k_q)
						AX_PITCH: pitch_q <= signed'(bl_new[31:0]);
						AX_ROLL: roll_q <= signed'(bl_new[31:0]);
						default: yaw_q <= signed'(bl_new[31:0]);
					endcase
					if (k_q == AX_YAW) begin
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= S_ASIN;
					end
				end
				S_OUT: if (!out_valid_q || !out_stall) begin
					pa_q <= pitch_q;
					ra_q <= roll_q;
					ya_q <= yaw_q;
					inv_out_q <= invalid_q;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ICAF_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_q != S_IDLE, "accepted request left the unit idle")
	`ICAF_ASSERT_NEXT(a_out_load, state_q == S_OUT && (!out_valid_q || !out_stall), out_valid_q && state_q == S_IDLE, "finished result not loaded")
	`ICAF_ASSERT_NOW(a_norm_pos, state_q == S_NORM, !x_q[47] && !y_q[47], "negative operand in normalisation")

endmodule

>>> bench/imu_complementary_attitude_filter_unit_test.sv
// Self-checking bench for the attitude filter unit: random bursty requests,
// a shadow attitude predictor, and result checks against a queue of expectations.
// Depends on imu_caf_pkg and the imu_complementary_attitude_filter_unit top level.
`timescale 1ns / 1ps
module imu_complementary_attitude_filter_unit_test;
	import imu_caf_pkg::*;

	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;
	localparam longint CYCLE_LIMIT = 8000000;
	localparam int HOLD_OFF_CYCLES = 4000;

	typedef struct {
		sword_t rx, ry, rz, ax, ay, az;
	} imu_sample_t;

	typedef struct {
		sword_t pitch, roll, yaw;
		logic invalid;
	} attitude_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	word_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	sword_t rate_x = '0, rate_y = '0, rate_z = '0;
	sword_t accel_x = '0, accel_y = '0, accel_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sword_t pitch_angle, roll_angle, yaw_angle;
	logic accel_invalid;

	imu_sample_t pending_samples[$];
	attitude_t expected_attitudes[$];
	int mismatch_count = 0;
	int results_seen = 0;
	longint cycle_count = 0;

	longint unsigned time_step_q, accel_weight_q;
	longint pitch_est, roll_est, yaw_est;
	longint atan_tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
		32, 16, 8, 4, 2, 1, 0};

	imu_complementary_attitude_filter_unit i_dut (.*);

	always #5 clk = ~clk;

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint product_round(longint a, longint b, int sh);
		logic neg;
		longint unsigned p;
		neg = (a < 0) != (b < 0);
		p = magnitude(a) * magnitude(b);
		p = (p + (64'd1 << (sh - 1))) >> sh;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint sine_q30(longint a);
		longint x, y, z, nx;
		x = INV_GAIN_Q30;
		y = 0;
		if (a > longint'(HALF_PI_Q30)) a = longint'(PI_Q30) - a;
		else if (a < -longint'(HALF_PI_Q30)) a = -longint'(PI_Q30) - a;
		z = a;
		for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_tab[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_tab[i];
			end
			x = nx;
		end
		return y;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint tilt_angle(longint a, longint b, longint c);
		longint unsigned ux, uy, mx;
		longint x, y, z, nx;
		ux = int_sqrt(magnitude(b) * magnitude(b) + magnitude(c) * magnitude(c));
		uy = magnitude(a);
		mx = ux > uy ? ux : uy;
		while (mx < (64'd1 << 40)) begin
			mx <<= 1;
			ux <<= 1;
			uy <<= 1;
		end
		x = ux;
		y = uy;
		z = 0;
		for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_tab[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_tab[i];
			end
			x = nx;
		end
		if (a < 0) z = -z;
		return (z + 8192) >>> 14;
	endfunction

	function automatic longint weighted_blend(longint est, longint acc);
		longint unsigned u;
		u = longint'(est) * ((64'd1 << 32) - accel_weight_q) + longint'(acc) * accel_weight_q;
		return longint'(u + 64'h8000_0000) >>> 32;
	endfunction

	function automatic attitude_t update_attitude(imu_sample_t s);
		attitude_t r;
		longint dt, ang, sn;
		longint unsigned m30;
		dt = time_step_q;
		pitch_est = clamp32(pitch_est + product_round(s.ry, dt, 32));
		roll_est = clamp32(roll_est + product_round(s.rx, dt, 32));
		yaw_est = clamp32(yaw_est + product_round(s.rz, dt, 32));
		m30 = (magnitude(s.rz) * time_step_q + (64'd1 << 17)) >> 18;
		ang = m30 % longint'(TWO_PI_Q30);
		if (ang > longint'(PI_Q30)) ang -= longint'(TWO_PI_Q30);
		if (s.rz < 0) ang = -ang;
		sn = sine_q30(ang);
		roll_est = clamp32(roll_est - product_round(pitch_est, sn, 30));
		pitch_est = clamp32(pitch_est + product_round(roll_est, sn, 30));
		r.invalid = s.ax == 0 && s.ay == 0 && s.az == 0;
		if (!r.invalid) begin
			pitch_est = weighted_blend(pitch_est, tilt_angle(s.ax, s.ay, s.az));
			roll_est = weighted_blend(roll_est, tilt_angle(s.ay, s.ax, s.az));
			yaw_est = weighted_blend(yaw_est, tilt_angle(s.az, s.ax, s.ay));
		end
		r.pitch = pitch_est[31:0];
		r.roll = roll_est[31:0];
		r.yaw = yaw_est[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at cycle %0d, result %0d: %s got %0d, want %0d",
			cycle_count, results_seen, what, got, want);
		mismatch_count++;
	endtask

	// driver: bursts of requests with random gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_attitudes.push_back(update_attitude(pending_samples[0]));
			pending_samples.pop_front();
		end
		if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				imu_sample_t s;
				s = pending_samples[0];
				rate_x <= s.rx; rate_y <= s.ry; rate_z <= s.rz;
				accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 6);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check results, stall on its own pattern, one long hold-off
	int stall_mode = 0, mode_left = 0, hold_left = 0;
	logic held_off = 1'b0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			attitude_t w;
			results_seen++;
			if (expected_attitudes.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				w = expected_attitudes.pop_front();
				if (pitch_angle !== w.pitch) report_mismatch("pitch", pitch_angle, w.pitch);
				if (roll_angle !== w.roll) report_mismatch("roll", roll_angle, w.roll);
				if (yaw_angle !== w.yaw) report_mismatch("yaw", yaw_angle, w.yaw);
				if (accel_invalid !== w.invalid)
					report_mismatch("accel_invalid", accel_invalid, w.invalid);
			end
		end
		if (!held_off && results_seen == 300) begin
			held_off = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 2000);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= $urandom_range(0, 3) == 0;
				2: out_stall <= $urandom_range(0, 1);
				default: out_stall <= $urandom_range(0, 7) != 0;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_register(logic [1:0] idx, word_t v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TIME_STEP) time_step_q = v;
		else if (idx == CFG_ACCEL_WEIGHT) accel_weight_q = v;
	endtask

	task automatic drain;
		while (pending_samples.size() > 0 || in_valid || expected_attitudes.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic sword_t rand_field(int kind);
		case (kind)
			0: return $urandom;
			1: return sword_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			2: return sword_t'($urandom_range(0, 32'h0000_1000)) - 32'sh0000_0800;
			default: return sword_t'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
		endcase
	endfunction

	task automatic add_sample(sword_t rx, sword_t ry, sword_t rz,
		sword_t ax, sword_t ay, sword_t az);
		imu_sample_t s;
		s.rx = rx; s.ry = ry; s.rz = rz; s.ax = ax; s.ay = ay; s.az = az;
		pending_samples.push_back(s);
	endtask

	task automatic add_random(int count);
		int rk, ak;
		for (int n = 0; n < count; n++) begin
			rk = $urandom_range(0, 3);
			ak = $urandom_range(0, 3);
			if ($urandom_range(0, 9) == 0)
				add_sample(rand_field(rk), rand_field(rk), rand_field(rk), 0, 0, 0);
			else
				add_sample(rand_field(rk), rand_field(rk), rand_field(rk),
					rand_field(ak), rand_field(ak), rand_field(ak));
		end
	endtask

	localparam sword_t SMAX = 32'sh7fff_ffff;
	localparam sword_t SMIN = 32'sh8000_0000;

	initial begin
		time_step_q = TIME_STEP_RST;
		accel_weight_q = ACCEL_WEIGHT_RST;
		pitch_est = 0; roll_est = 0; yaw_est = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes, zero vector, single axes, saturation, sine folding
		add_sample(0, 0, 0, 0, 0, 0);
		add_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 32'sh0001_0000);
		add_sample(0, 0, 0, 32'sh0001_0000, 0, 0);
		add_sample(0, 0, 0, 0, 32'sh0001_0000, 0);
		add_sample(0, 0, 0, 0, 0, -32'sh0001_0000);
		add_sample(0, 0, 0, 1, 0, 0);
		add_sample(0, 0, 0, 0, 0, -1);
		add_sample(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
		add_sample(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
		add_sample(SMAX, SMIN, SMAX, SMIN, SMAX, 0);
		add_sample(SMIN, SMAX, SMIN, 0, 0, 0);
		add_sample(1, -1, 1, -1, 1, -1);
		drain();
		write_register(CFG_TIME_STEP, 32'hffff_ffff);
		write_register(CFG_ACCEL_WEIGHT, 32'hffff_ffff);
		write_register(CFG_SPARE_A, 32'h1234_5678);
		write_register(CFG_SPARE_B, 32'hdead_beef);
		add_sample(SMAX, SMAX, 32'sh0003_243f, SMAX, 0, 0);
		add_sample(SMIN, SMIN, -32'sh0003_243f, 0, SMIN, 0);
		add_sample(0, 0, 32'sh0001_921f, 0, 0, 0);
		add_sample(0, 0, 32'sh0006_487f, 32'sh1, 32'sh1, 32'sh1);
		add_sample(SMAX, SMAX, SMAX, 0, 0, 0);
		drain();
		write_register(CFG_TIME_STEP, 0);
		write_register(CFG_ACCEL_WEIGHT, 0);
		add_sample(SMAX, SMIN, SMAX, 5, 3, 7);
		add_sample(SMIN, SMAX, SMIN, 0, 0, 0);
		drain();

		write_register(CFG_TIME_STEP, TIME_STEP_RST);
		write_register(CFG_ACCEL_WEIGHT, ACCEL_WEIGHT_RST);
		add_random(400);
		drain();
		write_register(CFG_TIME_STEP, $urandom);
		write_register(CFG_ACCEL_WEIGHT, $urandom);
		add_random(300);
		drain();
		write_register(CFG_TIME_STEP, 32'hffff_ffff);
		write_register(CFG_ACCEL_WEIGHT, 0);
		add_random(200);
		drain();
		write_register(CFG_TIME_STEP, $urandom_range(0, 32'h0400_0000));
		write_register(CFG_ACCEL_WEIGHT, 32'hffff_ffff);
		add_random(300);
		drain();

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
